/* rtl/clrle_pkg.sv */
`timescale 1ns / 1ps

package clrle_pkg;

    localparam int unsigned DEF_OUTPUT_CAP = 320;

    localparam int CL_W      = 4;
    localparam int RUN_W     = 8;
    localparam int SYM_W     = 5;
    localparam int EB_W      = 3;
    localparam int EV_W      = 7;
    localparam int IDX_W     = 9;
    localparam int RES_N_W   = 5;

    localparam logic [RUN_W-1:0]   RUN_CAP        = 8'd138;
    localparam logic [RUN_W-1:0]   LONG_ZERO_MIN  = 8'd11;
    localparam logic [RUN_W-1:0]   SHORT_ZERO_MIN = 8'd3;
    localparam logic [RUN_W-1:0]   REPEAT_MIN     = 8'd3;
    localparam logic [RUN_W-1:0]   REPEAT_MAX     = 8'd6;
    localparam logic [RES_N_W-1:0] MAX_RESULTS    = 5'd25;

    localparam logic [SYM_W-1:0] SYM_REPEAT     = 5'd16;
    localparam logic [SYM_W-1:0] SYM_ZERO_SHORT = 5'd17;
    localparam logic [SYM_W-1:0] SYM_ZERO_LONG  = 5'd18;

    localparam logic [EB_W-1:0] EB_NONE       = 3'd0;
    localparam logic [EB_W-1:0] EB_REPEAT     = 3'd2;
    localparam logic [EB_W-1:0] EB_ZERO_SHORT = 3'd3;
    localparam logic [EB_W-1:0] EB_ZERO_LONG  = 3'd7;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic accept;
        logic step;
        logic end_seq;
    } t_dp_cmd;

    typedef struct packed {
        logic need_flush;
        logic flush_done;
        logic second_pending;
        logic out_ready;
    } t_dp_status;

endpackage

/* rtl/code_length_run_length_encoder.sv */
`timescale 1ns / 1ps
// code-length run-length encoder for the deflate code-length alphabet
// input channel: i_valid / o_stall carries one code length and an is_last flag;
//   a transaction completes on a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carries symbol, extra bits, extra value,
//   position in the sequence and a flag on the final result of a transaction
// an item that only extends the open run gives no result
// an item that closes a run (value change, run of 138, or is_last) holds
//   o_stall high while the flush engine emits one result per cycle, unless the
//   receiver stalls; the first result goes through the flush engine registers
//   and then the output register; the block takes input again once the final result is loaded
// one flush engine walks each run one symbol at a time, which sets the rate
// results at positions OUTPUT_CAP and above are dropped silently
// is_last resets the position count for the next sequence
// a stalled receiver holds the output register and, through it, the engine;
//   the input side then stays stalled until the engine is done
// reset (synchronous, active low) clears the open run, the position count
//   and the output valid
module code_length_run_length_encoder #(
    parameter int unsigned OUTPUT_CAP = clrle_pkg::DEF_OUTPUT_CAP
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [clrle_pkg::CL_W-1:0]  i_code_length,
    input  logic                        i_is_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [clrle_pkg::SYM_W-1:0] o_symbol,
    output logic [clrle_pkg::EB_W-1:0]  o_extra_bits,
    output logic [clrle_pkg::EV_W-1:0]  o_extra_field,
    output logic [clrle_pkg::IDX_W-1:0] o_emitted_index,
    output logic                        o_last_of_batch
);

    clrle_pkg::t_dp_cmd    dp_cmd;
    clrle_pkg::t_dp_status dp_status;

    clrle_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    clrle_dp #(
        .OUTPUT_CAP (OUTPUT_CAP)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_code_length   (i_code_length),
        .i_is_last       (i_is_last),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_symbol        (o_symbol),
        .o_extra_bits    (o_extra_bits),
        .o_extra_field   (o_extra_field),
        .o_emitted_index (o_emitted_index),
        .o_last_of_batch (o_last_of_batch)
    );

endmodule

/* rtl/clrle_ctrl.sv */
`timescale 1ns / 1ps

module clrle_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  clrle_pkg::t_dp_status i_status,
    output clrle_pkg::t_dp_cmd    o_cmd
);

    clrle_pkg::t_state r_state;
    clrle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clrle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.accept  = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.end_seq = 1'b0;
        o_stall       = 1'b1;
        case (r_state)
            clrle_pkg::ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
                if (i_valid && i_status.need_flush) begin
                    n_state = clrle_pkg::ST_FLUSH;
                end
            end
            clrle_pkg::ST_FLUSH: begin
                o_cmd.step = i_status.out_ready;
                // last symbol of the last flush closes the transaction
                if (i_status.out_ready && i_status.flush_done && !i_status.second_pending) begin
                    o_cmd.end_seq = 1'b1;
                    n_state       = clrle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = clrle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/clrle_dp.sv */
`timescale 1ns / 1ps

module clrle_dp #(
    parameter int unsigned OUTPUT_CAP = clrle_pkg::DEF_OUTPUT_CAP
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  clrle_pkg::t_dp_cmd                  i_cmd,
    output clrle_pkg::t_dp_status               o_status,
    input  logic [clrle_pkg::CL_W-1:0]          i_code_length,
    input  logic                                i_is_last,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [clrle_pkg::SYM_W-1:0]         o_symbol,
    output logic [clrle_pkg::EB_W-1:0]          o_extra_bits,
    output logic [clrle_pkg::EV_W-1:0]          o_extra_field,
    output logic [clrle_pkg::IDX_W-1:0]         o_emitted_index,
    output logic                                o_last_of_batch
);

    localparam int EW = $clog2(OUTPUT_CAP + 1);
    localparam logic [EW:0] CAP_VAL = (EW + 1)'(OUTPUT_CAP);

    // open run
    logic [clrle_pkg::CL_W-1:0]    r_run_value;
    logic [clrle_pkg::RUN_W-1:0]   r_run_length;
    logic [EW-1:0]                 r_emit_cnt;
    logic [clrle_pkg::RES_N_W-1:0] r_res_n;
    logic                          r_last;
    logic                          r_second;

    // flush engine
    logic [clrle_pkg::CL_W-1:0]  r_f_val;
    logic [clrle_pkg::RUN_W-1:0] r_f_cnt;
    logic                        r_f_first;

    // output register
    logic                         r_out_valid;
    logic [clrle_pkg::SYM_W-1:0]  r_out_symbol;
    logic [clrle_pkg::EB_W-1:0]   r_out_eb;
    logic [clrle_pkg::EV_W-1:0]   r_out_ev;
    logic [clrle_pkg::IDX_W-1:0]  r_out_idx;
    logic                         r_out_last;

    logic                         out_ready;
    logic                         flush_old;
    logic [clrle_pkg::RUN_W-1:0]  new_len;
    logic                         hit_cap;

    logic [clrle_pkg::SYM_W-1:0]  f_sym;
    logic [clrle_pkg::EB_W-1:0]   f_eb;
    logic [clrle_pkg::EV_W-1:0]   f_ev;
    logic [clrle_pkg::RUN_W-1:0]  n_f_cnt;
    logic [clrle_pkg::RUN_W-1:0]  take;
    logic                         f_done;
    logic                         put_ok;
    logic                         next_drop;
    logic [EW:0]                  cnt_plus;

    assign out_ready = !r_out_valid || !i_stall;
    assign flush_old = (r_run_length != '0) && (i_code_length != r_run_value);
    assign new_len   = (r_run_length == '0) ? clrle_pkg::RUN_W'(1)
                                            : r_run_length + clrle_pkg::RUN_W'(1);
    assign hit_cap   = (new_len >= clrle_pkg::RUN_CAP);

    // symbol for the current flush position
    always_comb begin
        f_sym   = {1'b0, r_f_val};
        f_eb    = clrle_pkg::EB_NONE;
        f_ev    = '0;
        n_f_cnt = r_f_cnt - clrle_pkg::RUN_W'(1);
        take    = (r_f_cnt > clrle_pkg::REPEAT_MAX) ? clrle_pkg::REPEAT_MAX : r_f_cnt;
        f_done  = (r_f_cnt == clrle_pkg::RUN_W'(1));
        if (r_f_first) begin
            if (r_f_val == '0 && r_f_cnt >= clrle_pkg::LONG_ZERO_MIN) begin
                f_sym  = clrle_pkg::SYM_ZERO_LONG;
                f_eb   = clrle_pkg::EB_ZERO_LONG;
                f_ev   = clrle_pkg::EV_W'(r_f_cnt - clrle_pkg::LONG_ZERO_MIN);
                f_done = 1'b1;
            end else if (r_f_val == '0 && r_f_cnt >= clrle_pkg::SHORT_ZERO_MIN) begin
                f_sym  = clrle_pkg::SYM_ZERO_SHORT;
                f_eb   = clrle_pkg::EB_ZERO_SHORT;
                f_ev   = clrle_pkg::EV_W'(r_f_cnt - clrle_pkg::SHORT_ZERO_MIN);
                f_done = 1'b1;
            end
        end else if (r_f_cnt >= clrle_pkg::REPEAT_MIN) begin
            f_sym   = clrle_pkg::SYM_REPEAT;
            f_eb    = clrle_pkg::EB_REPEAT;
            f_ev    = clrle_pkg::EV_W'(take - clrle_pkg::REPEAT_MIN);
            n_f_cnt = r_f_cnt - take;
            f_done  = (r_f_cnt == take);
        end
    end

    assign cnt_plus  = {1'b0, r_emit_cnt} + (EW + 1)'(1);
    assign put_ok    = ({1'b0, r_emit_cnt} < CAP_VAL) && (r_res_n < clrle_pkg::MAX_RESULTS);
    // once a put would be dropped, every later one in this transaction is too
    assign next_drop = (cnt_plus >= CAP_VAL)
                    || (r_res_n >= clrle_pkg::MAX_RESULTS - clrle_pkg::RES_N_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_value  <= '0;
            r_run_length <= '0;
            r_emit_cnt   <= '0;
            r_res_n      <= '0;
            r_last       <= 1'b0;
            r_second     <= 1'b0;
            r_f_first    <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_last  <= i_is_last;
                r_res_n <= '0;
                if (flush_old) begin
                    r_f_val      <= r_run_value;
                    r_f_cnt      <= r_run_length;
                    r_f_first    <= 1'b1;
                    r_run_value  <= i_code_length;
                    r_run_length <= clrle_pkg::RUN_W'(1);
                    r_second     <= i_is_last;
                end else if (hit_cap || i_is_last) begin
                    r_f_val      <= i_code_length;
                    r_f_cnt      <= new_len;
                    r_f_first    <= 1'b1;
                    r_run_value  <= '0;
                    r_run_length <= '0;
                    r_second     <= 1'b0;
                end else begin
                    r_run_value  <= i_code_length;
                    r_run_length <= new_len;
                end
            end else if (i_cmd.step) begin
                if (put_ok) begin
                    r_res_n <= r_res_n + clrle_pkg::RES_N_W'(1);
                end
                if (f_done && r_second) begin
                    r_f_val      <= r_run_value;
                    r_f_cnt      <= r_run_length;
                    r_f_first    <= 1'b1;
                    r_run_value  <= '0;
                    r_run_length <= '0;
                    r_second     <= 1'b0;
                end else begin
                    r_f_cnt   <= n_f_cnt;
                    r_f_first <= 1'b0;
                end
            end
            if (i_cmd.end_seq && r_last) begin
                r_emit_cnt <= '0;
            end else if (i_cmd.step && put_ok) begin
                r_emit_cnt <= cnt_plus[EW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= i_cmd.step && put_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && put_ok) begin
            r_out_symbol <= f_sym;
            r_out_eb     <= f_eb;
            r_out_ev     <= f_ev;
            r_out_idx    <= clrle_pkg::IDX_W'(r_emit_cnt);
            r_out_last   <= next_drop || (f_done && !r_second);
        end
    end

    assign o_status.need_flush     = flush_old || hit_cap || i_is_last;
    assign o_status.flush_done     = f_done;
    assign o_status.second_pending = r_second;
    assign o_status.out_ready      = out_ready;

    assign o_valid         = r_out_valid;
    assign o_symbol        = r_out_symbol;
    assign o_extra_bits    = r_out_eb;
    assign o_extra_field   = r_out_ev;
    assign o_emitted_index = r_out_idx;
    assign o_last_of_batch = r_out_last;

endmodule

/* rtl/clrle_checker.sv */
`timescale 1ns / 1ps

module clrle_sva (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [clrle_pkg::SYM_W-1:0] o_symbol,
    input logic [clrle_pkg::EB_W-1:0]  o_extra_bits,
    input logic [clrle_pkg::EV_W-1:0]  o_extra_field,
    input logic [clrle_pkg::IDX_W-1:0] o_emitted_index,
    input logic                        o_last_of_batch
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_symbol) && $stable(o_extra_field)
            && $stable(o_emitted_index) && $stable(o_last_of_batch))
        else $error("stalled result changed");

    // a result that is not the last of its transaction means the flush is still running
    a_open_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_batch |-> o_stall)
        else $error("input taken while a batch is open");

    a_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_symbol == clrle_pkg::SYM_ZERO_LONG
            |-> o_extra_bits == clrle_pkg::EB_ZERO_LONG)
        else $error("long zero run with wrong extra bits");

    a_literal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_extra_bits == clrle_pkg::EB_NONE
            |-> o_extra_field == '0 && o_symbol < clrle_pkg::SYM_REPEAT)
        else $error("literal with extra value or bad symbol");

    a_repeat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_symbol == clrle_pkg::SYM_REPEAT
            |-> o_extra_bits == clrle_pkg::EB_REPEAT && o_extra_field < 7'd4)
        else $error("repeat count out of range");

endmodule

bind code_length_run_length_encoder clrle_sva u_clrle_sva (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_symbol        (o_symbol),
    .o_extra_bits    (o_extra_bits),
    .o_extra_field   (o_extra_field),
    .o_emitted_index (o_emitted_index),
    .o_last_of_batch (o_last_of_batch)
);
